[hw/rtl/gnce_pkg.sv]
package gnce_pkg;

    // Field and store geometry
    localparam int IDX_W      = 16;
    localparam int OCC_W      = 8;
    localparam int SIDE_W     = 9;
    localparam int COORD_W    = 8;
    localparam int MAX_SIDE   = 256;
    localparam int CELLS      = 65536;
    localparam int EDGE_W     = 17;
    localparam int HEUR_W     = 25;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS  = 16;
    localparam int ROOT_STEPS = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd4;

    // Commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_EXPAND = 1'b1;

    // Diagonal cost factor, sqrt(2) in Q7
    localparam logic signed [8:0] DIAG_MULT = 9'sd181;

    typedef logic signed [1:0] ofs_t;

    // Neighbor offsets: left, bottom, right, top, bl, tl, br, tr
    localparam ofs_t NB_DC [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                   -2'sd1, -2'sd1, 2'sd1, 2'sd1};
    localparam ofs_t NB_DR [8] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1,
                                   -2'sd1, 2'sd1, -2'sd1, 2'sd1};

    typedef struct packed {
        logic [SIDE_W-1:0] grid_width;
        logic [SIDE_W-1:0] grid_height;
        logic [15:0]       goal_x;
        logic [15:0]       goal_y;
        logic [15:0]       cell_size;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]   nidx;
        logic [IDX_W-1:0]   center;
        logic [COORD_W-1:0] nc;
        logic [COORD_W-1:0] nr;
        logic               diag;
        logic               last;
        logic               first;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_GEN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CRD,
        B_NRD,
        B_NCAP,
        B_SQX,
        B_SQY,
        B_ROOT,
        B_MUL
    } back_state_t;

    // Out-of-range dimensions act as the nearest legal one
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (v > SIDE_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hw/rtl/gnce_ram.sv]
module gnce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/gnce_front.sv]
module gnce_front import gnce_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             cmd,
    input  logic [IDX_W-1:0] cell_index,
    input  cfg_t             cfg,
    input  logic             full,
    output logic             push,
    output job_t             push_job,
    output logic             idle
);

    front_state_t state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SIDE_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0]  quo_reg, quo_next;
    logic [3:0]        step_reg, step_next;
    logic [2:0]        k_reg, k_next;
    logic              first_reg, first_next;

    logic [SIDE_W-1:0]   w, h;
    logic [2*SIDE_W-1:0] area;
    logic                in_grid;
    logic [SIDE_W:0]     trial;
    logic                ge;
    logic [COORD_W-1:0]  col, row;
    logic                ok_l, ok_b, ok_r, ok_t;
    logic [7:0]          mask;
    logic [7:0]          keep;
    logic                advance;
    logic signed [17:0]  row_ofs, nidx_s;
    ofs_t                dc, dr;

    assign w       = clamp_side(cfg.grid_width);
    assign h       = clamp_side(cfg.grid_height);
    assign area    = w * h;
    assign in_grid = {2'b00, cell_index} < area;

    // Restoring divide step, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[IDX_W-1]};
    assign ge    = trial >= {1'b0, w};

    assign col = rem_reg[COORD_W-1:0];
    assign row = quo_reg[COORD_W-1:0];

    // In-grid neighbors
    assign ok_l = col != '0;
    assign ok_b = row != '0;
    assign ok_r = {1'b0, col} + 9'd1 < w;
    assign ok_t = {1'b0, row} + 9'd1 < h;
    assign mask = {ok_r & ok_t, ok_r & ok_b, ok_l & ok_t, ok_l & ok_b,
                   ok_t, ok_r, ok_b, ok_l};
    assign keep = 8'hFE << k_reg;

    assign dc = NB_DC[k_reg];
    assign dr = NB_DR[k_reg];

    always_comb
    begin
        if (dr < 0)
        begin
            row_ofs = -$signed({9'd0, w});
        end
        else if (dr > 0)
        begin
            row_ofs = $signed({9'd0, w});
        end
        else
        begin
            row_ofs = '0;
        end
    end

    assign nidx_s = $signed({2'b00, idx_reg}) + 18'(dc) + row_ofs;

    assign push    = (state_reg == F_GEN) && mask[k_reg] && !full;
    assign advance = (state_reg == F_GEN) && (!mask[k_reg] || !full);

    always_comb
    begin
        push_job.nidx   = nidx_s[IDX_W-1:0];
        push_job.center = idx_reg;
        push_job.nc     = col + COORD_W'(dc);
        push_job.nr     = row + COORD_W'(dr);
        push_job.diag   = (dc != 0) && (dr != 0);
        push_job.last   = (mask & keep) == '0;
        push_job.first  = first_reg;
    end

    assign idle = state_reg == F_IDLE;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        first_next = first_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && (cmd == CMD_EXPAND) && in_grid)
                begin
                    idx_next   = cell_index;
                    rem_next   = '0;
                    quo_next   = cell_index;
                    step_next  = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next  = ge ? SIDE_W'(trial - {1'b0, w}) : trial[SIDE_W-1:0];
                quo_next  = {quo_reg[IDX_W-2:0], ge};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(DIV_STEPS - 1))
                begin
                    k_next     = '0;
                    first_next = 1'b1;
                    state_next = F_GEN;
                end
            end
            F_GEN:
            begin
                if (push)
                begin
                    first_next = 1'b0;
                end
                if (advance)
                begin
                    k_next = k_reg + 3'd1;
                    if (k_reg == 3'd7)
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/gnce_queue.sv]
module gnce_queue import gnce_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign head  = entries_reg[rd_ptr_reg];
    assign full  = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/gnce_back.sv]
module gnce_back import gnce_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     empty,
    input  job_t                     head,
    output logic                     pop,
    output logic [IDX_W-1:0]         raddr,
    input  logic [OCC_W-1:0]         rdata,
    output logic                     active,
    output logic                     result_valid,
    output logic [IDX_W-1:0]         neighbor_index,
    output logic signed [EDGE_W-1:0] edge_cost,
    output logic [HEUR_W-1:0]        heuristic,
    output logic                     last
);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic signed [OCC_W-1:0] occ_c_reg, occ_c_next, occ_n_reg, occ_n_next;
    logic [33:0] x_reg, x_next;
    logic [19:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [4:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic        last_reg, last_next;
    logic [IDX_W-1:0]         nidx_out_reg, nidx_out_next;
    logic signed [EDGE_W-1:0] cost_reg, cost_next;
    logic [HEUR_W-1:0]        heur_reg, heur_next;

    logic signed [17:0] dx, dy, dsel;
    logic signed [35:0] dsq;
    logic [19:0]        rem_sh, trial;
    logic               ge;
    logic [32:0]        heur_prod;
    logic signed [8:0]  occ_sum;
    logic signed [17:0] cost_diag;
    logic signed [15:0] cost_side;

    // Offset of the neighbor center from the goal, Q8 cells
    assign dx   = $signed({2'b00, cfg.goal_x}) - $signed({2'b00, job_reg.nc, 8'h80});
    assign dy   = $signed({2'b00, cfg.goal_y}) - $signed({2'b00, job_reg.nr, 8'h80});
    assign dsel = (state_reg == B_SQX) ? dx : dy;
    assign dsq  = dsel * dsel;

    // Square root, two radicand bits a step
    assign rem_sh = {rem_reg[17:0], x_reg[33:32]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    assign heur_prod = root_reg * cfg.cell_size;
    assign occ_sum   = {occ_c_reg[OCC_W-1], occ_c_reg} + {occ_n_reg[OCC_W-1], occ_n_reg};
    assign cost_diag = occ_sum * DIAG_MULT;
    assign cost_side = {occ_sum, 7'b0};

    assign pop    = (state_reg == B_IDLE) && !empty;
    assign raddr  = (state_reg == B_CRD) ? job_reg.center : job_reg.nidx;
    assign active = state_reg != B_IDLE;

    assign result_valid   = valid_reg;
    assign neighbor_index = nidx_out_reg;
    assign edge_cost      = cost_reg;
    assign heuristic      = heur_reg;
    assign last           = valid_reg & last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        occ_c_reg    <= occ_c_next;
        occ_n_reg    <= occ_n_next;
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        last_reg     <= last_next;
        nidx_out_reg <= nidx_out_next;
        cost_reg     <= cost_next;
        heur_reg     <= heur_next;
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        occ_c_next    = occ_c_reg;
        occ_n_next    = occ_n_reg;
        x_next        = x_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        step_next     = step_reg;
        valid_next    = 1'b0;
        last_next     = last_reg;
        nidx_out_next = nidx_out_reg;
        cost_next     = cost_reg;
        heur_next     = heur_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    job_next   = head;
                    state_next = head.first ? B_CRD : B_NRD;
                end
            end
            B_CRD:
            begin
                state_next = B_NRD;
            end
            B_NRD:
            begin
                if (job_reg.first)
                begin
                    occ_c_next = rdata;
                end
                state_next = B_NCAP;
            end
            B_NCAP:
            begin
                occ_n_next = rdata;
                state_next = B_SQX;
            end
            B_SQX:
            begin
                x_next     = {1'b0, dsq[32:0]};
                state_next = B_SQY;
            end
            B_SQY:
            begin
                x_next     = x_reg + {1'b0, dsq[32:0]};
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                rem_next  = ge ? rem_sh - trial : rem_sh;
                root_next = {root_reg[15:0], ge};
                x_next    = {x_reg[31:0], 2'b00};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(ROOT_STEPS - 1))
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                heur_next     = heur_prod[32:8];
                cost_next     = job_reg.diag ? cost_diag[EDGE_W-1:0]
                                             : EDGE_W'(cost_side);
                nidx_out_next = job_reg.nidx;
                last_next     = job_reg.last;
                valid_next    = 1'b1;
                state_next    = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/grid_neighbor_cost_expander.sv]
// Eight-connected grid neighbor expander for A* search.
//
// Command channel: an item transfers at a rising edge with start high and
// busy low. cmd 0 writes occupancy to the store at cell_index and leaves
// busy low. cmd 1 expands cell_index: busy rises, the index is split into
// column and row, and each in-grid neighbor leaves on the result ports for
// one cycle with result_valid high, last marking the final one. An index
// outside the grid transfers, leaves busy low and yields nothing. The back
// end finishes one neighbor before it takes the next: it reads the
// neighbor's occupancy from the store (the first neighbor also reads the
// center), takes the 17-step square root for the heuristic, scales it by
// cell_size and forms the edge cost. The last result of an expansion shows
// with busy already low in that cycle.
// Results cannot be held off: they are shown exactly once.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
// once and belong only where busy is low.
// Reset restores the register defaults; the occupancy store is not cleared,
// so cells must be written before they are expanded or used as neighbors.
module grid_neighbor_cost_expander import gnce_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [IDX_W-1:0]         cell_index,
    input  logic signed [OCC_W-1:0]  occupancy,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     result_valid,
    output logic [IDX_W-1:0]         neighbor_index,
    output logic signed [EDGE_W-1:0] edge_cost,
    output logic [HEUR_W-1:0]        heuristic,
    output logic                     last
);

    cfg_t             cfg_reg;
    logic             accept;
    logic             front_idle, back_active;
    logic             push, pop, full, empty;
    job_t             push_job, head;
    logic [IDX_W-1:0] raddr;
    logic [OCC_W-1:0] rdata;

    assign accept = start && !busy;
    assign busy   = !front_idle || !empty || back_active;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= SIDE_W'(256);
            cfg_reg.grid_height <= SIDE_W'(256);
            cfg_reg.goal_x      <= '0;
            cfg_reg.goal_y      <= '0;
            cfg_reg.cell_size   <= 16'd256;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  cfg_reg.grid_width  <= cfg_data[SIDE_W-1:0];
                REG_GRID_HEIGHT: cfg_reg.grid_height <= cfg_data[SIDE_W-1:0];
                REG_GOAL_X:      cfg_reg.goal_x      <= cfg_data;
                REG_GOAL_Y:      cfg_reg.goal_y      <= cfg_data;
                REG_CELL_SIZE:   cfg_reg.cell_size   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Occupancy store
    gnce_ram #(
        .WIDTH (OCC_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (accept && (cmd == CMD_WRITE)),
        .waddr (cell_index),
        .wdata (occupancy),
        .raddr (raddr),
        .rdata (rdata)
    );

    gnce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .cell_index (cell_index),
        .cfg        (cfg_reg),
        .full       (full),
        .push       (push),
        .push_job   (push_job),
        .idle       (front_idle)
    );

    gnce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    gnce_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .raddr          (raddr),
        .rdata          (rdata),
        .active         (back_active),
        .result_valid   (result_valid),
        .neighbor_index (neighbor_index),
        .edge_cost      (edge_cost),
        .heuristic      (heuristic),
        .last           (last)
    );

endmodule

[hw/rtl/gnce_checker.sv]
module gnce_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic last
);

    // More neighbors follow a result that is not the last
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final result while idle");

    // An idle block has nothing left to deliver
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result after idle cycle");

    // Results never come in consecutive cycles
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back-to-back results");

    // last only marks a result
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid)
        else $error("last without result");

endmodule

bind grid_neighbor_cost_expander gnce_checker u_checker (.*);

[tb/sv/tb_grid_neighbor_cost_expander.sv]
`timescale 1ns / 1ps

module tb_grid_neighbor_cost_expander;
    import gnce_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic signed [OCC_W-1:0]  occ;
    } cell_cmd_t;

    typedef struct {
        logic [IDX_W-1:0]         nidx;
        logic signed [EDGE_W-1:0] cost;
        logic [HEUR_W-1:0]        heur;
        logic                     last;
    } neighbor_t;

    logic clk = 1'b1;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cmd = CMD_WRITE;
    logic [IDX_W-1:0] cell_index = '0;
    logic signed [OCC_W-1:0] occupancy = '0;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic busy;
    logic result_valid;
    logic [IDX_W-1:0] neighbor_index;
    logic signed [EDGE_W-1:0] edge_cost;
    logic [HEUR_W-1:0] heuristic;
    logic last;

    // Shadow registers and occupancy store
    logic [SIDE_W-1:0] sh_width = 9'd256;
    logic [SIDE_W-1:0] sh_height = 9'd256;
    logic [15:0] sh_goal_x = '0;
    logic [15:0] sh_goal_y = '0;
    logic [15:0] sh_cell_size = 16'd256;
    logic signed [OCC_W-1:0] occ_shadow [CELLS];
    bit written [CELLS];

    cell_cmd_t cmd_queue [$];
    neighbor_t neighbor_queue [$];
    int idle_pct = 0;
    int fail_cnt = 0;
    int n_expands = 0;
    int n_writes = 0;
    int n_results = 0;
    int n_cfg = 0;
    int n_sent = 0;
    int stall_cycles = 0;

    grid_neighbor_cost_expander u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .cell_index     (cell_index),
        .occupancy      (occupancy),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .neighbor_index (neighbor_index),
        .edge_cost      (edge_cost),
        .heuristic      (heuristic),
        .last           (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int side_of(input logic [SIDE_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_SIDE)
        begin
            return MAX_SIDE;
        end
        return int'(v);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Neighbor costs and goal distances for one expansion
    task automatic expand_costs(input logic [IDX_W-1:0] idx);
        int w;
        int h;
        int col;
        int row;
        int nc;
        int nr;
        int occ_c;
        int mult;
        int first_new;
        longint dx;
        longint dy;
        longint unsigned root_val;
        longint unsigned heur;
        neighbor_t nb;
        w = side_of(sh_width);
        h = side_of(sh_height);
        first_new = neighbor_queue.size();
        if (int'(idx) >= w * h)
        begin
            return;
        end
        col = int'(idx) % w;
        row = int'(idx) / w;
        occ_c = int'(occ_shadow[idx]);
        for (int k = 0; k < 8; k++)
        begin
            nc = col + int'(NB_DC[k]);
            nr = row + int'(NB_DR[k]);
            if (nc < 0 || nc >= w || nr < 0 || nr >= h)
            begin
                continue;
            end
            mult = (NB_DC[k] != 0 && NB_DR[k] != 0) ? 181 : 128;
            nb.nidx = IDX_W'(nc + nr * w);
            nb.cost = EDGE_W'((occ_c + int'(occ_shadow[nb.nidx])) * mult);
            dx = longint'(sh_goal_x) - longint'(nc * 256 + 128);
            dy = longint'(sh_goal_y) - longint'(nr * 256 + 128);
            root_val = int_sqrt(longint'(dx * dx + dy * dy));
            heur = (root_val * longint'(sh_cell_size)) >> 8;
            nb.heur = (heur > 64'h1FFFFFF) ? '1 : HEUR_W'(heur);
            nb.last = 1'b0;
            neighbor_queue.push_back(nb);
        end
        if (neighbor_queue.size() > first_new)
        begin
            neighbor_queue[neighbor_queue.size() - 1].last = 1'b1;
        end
    endtask

    // Command driver: holds start until the transfer happens
    always @(posedge clk)
    begin
        cell_cmd_t nxt;
        bit done;
        if (rst_n)
        begin
            done = start && !busy;
            if (done)
            begin
                if (cmd == CMD_WRITE)
                begin
                    occ_shadow[cell_index] = occupancy;
                    n_writes++;
                end
                else
                begin
                    expand_costs(cell_index);
                    n_expands++;
                end
                void'(cmd_queue.pop_front());
            end
            if (!start || done)
            begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = cmd_queue[0];
                    start <= 1'b1;
                    cmd <= nxt.cmd;
                    cell_index <= nxt.idx;
                    occupancy <= nxt.occ;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        neighbor_t exp_nb;
        if (rst_n && result_valid)
        begin
            if (neighbor_queue.size() == 0)
            begin
                $error("unexpected result, neighbor_index %0d", neighbor_index);
                fail_cnt++;
            end
            else
            begin
                exp_nb = neighbor_queue.pop_front();
                n_results++;
                if (neighbor_index !== exp_nb.nidx)
                begin
                    $error("neighbor_index expected %0d actual %0d", exp_nb.nidx,
                           neighbor_index);
                    fail_cnt++;
                end
                if (edge_cost !== exp_nb.cost)
                begin
                    $error("edge_cost expected %0d actual %0d", exp_nb.cost, edge_cost);
                    fail_cnt++;
                end
                if (heuristic !== exp_nb.heur)
                begin
                    $error("heuristic expected %0d actual %0d", exp_nb.heur, heuristic);
                    fail_cnt++;
                end
                if (last !== exp_nb.last)
                begin
                    $error("last expected %0b actual %0b", exp_nb.last, last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || cfg_write_en)
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic push_write(input int idx, input logic signed [OCC_W-1:0] occ);
        cell_cmd_t c;
        c.cmd = CMD_WRITE;
        c.idx = IDX_W'(idx);
        c.occ = occ;
        cmd_queue.push_back(c);
        written[idx] = 1'b1;
        n_sent++;
    endtask

    task automatic push_expand(input int idx);
        cell_cmd_t c;
        c.cmd = CMD_EXPAND;
        c.idx = IDX_W'(idx);
        c.occ = OCC_W'($urandom);
        cmd_queue.push_back(c);
        n_sent++;
    endtask

    // Write unwritten in-grid cells around idx (center always if fixed), then expand
    task automatic prep_and_expand(input int idx, input bit rnd, input int fixed_occ);
        int w;
        int h;
        int col;
        int row;
        int nidx;
        w = side_of(sh_width);
        h = side_of(sh_height);
        col = idx % w;
        row = idx / w;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (col + dc < 0 || col + dc >= w || row + dr < 0 || row + dr >= h)
                begin
                    continue;
                end
                nidx = (col + dc) + (row + dr) * w;
                if (!written[nidx] || (!rnd && dr == 0 && dc == 0))
                begin
                    push_write(nidx, rnd ? OCC_W'($urandom) : OCC_W'(fixed_occ));
                end
            end
        end
        push_expand(idx);
    endtask

    // Wait until every queued transfer and result is done, then let the block settle
    task automatic settle();
        while (cmd_queue.size() != 0 || start || busy || neighbor_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val;
        case (ri)
            REG_GRID_WIDTH:  sh_width = val[SIDE_W-1:0];
            REG_GRID_HEIGHT: sh_height = val[SIDE_W-1:0];
            REG_GOAL_X:      sh_goal_x = val;
            REG_GOAL_Y:      sh_goal_y = val;
            REG_CELL_SIZE:   sh_cell_size = val;
            default: ;
        endcase
        n_cfg++;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int w;
        int h;
        int items;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset geometry, corners and extreme occupancy
        prep_and_expand(0, 1'b0, -128);
        prep_and_expand(65535, 1'b0, 127);
        prep_and_expand(32896, 1'b1, 0);
        settle();

        // Degenerate grid: zero width acts as one, 1x1 has no neighbors
        set_reg(REG_GRID_WIDTH, 16'd0);
        set_reg(REG_GRID_HEIGHT, 16'd1);
        push_expand(0);
        push_expand(5);
        settle();

        // Oversized dimensions clamp, zero cell size, far goal
        set_reg(REG_GRID_WIDTH, 16'd300);
        set_reg(REG_GRID_HEIGHT, 16'd511);
        set_reg(REG_CELL_SIZE, 16'd0);
        set_reg(REG_GOAL_X, 16'hFFFF);
        set_reg(REG_GOAL_Y, 16'hFFFF);
        push_expand(32896);
        settle();
        set_reg(REG_CELL_SIZE, 16'hFFFF);
        set_reg(3'd5, 16'h0003);
        set_reg(3'd7, 16'hFFFF);
        push_expand(0);
        push_expand(65535);
        settle();

        // 3x3 grid: center sees all eight neighbors, outside index yields nothing
        set_reg(REG_GRID_WIDTH, 16'd3);
        set_reg(REG_GRID_HEIGHT, 16'd3);
        set_reg(REG_GOAL_X, 16'd0);
        set_reg(REG_GOAL_Y, 16'd0);
        set_reg(REG_CELL_SIZE, 16'd256);
        prep_and_expand(4, 1'b0, 127);
        prep_and_expand(8, 1'b0, -1);
        push_expand(9);
        settle();

        // Random phases with fresh geometry each time
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph < 2) ? 11 : (ph < 4) ? 57 : 0;
            w = ($urandom_range(7) == 0) ? 256 : $urandom_range(1, 20);
            h = ($urandom_range(7) == 0) ? 256 : $urandom_range(1, 20);
            set_reg(REG_GRID_WIDTH, CFG_W'(w));
            set_reg(REG_GRID_HEIGHT, CFG_W'(h));
            set_reg(REG_GOAL_X, ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                : CFG_W'($urandom_range(0, w * 256)));
            set_reg(REG_GOAL_Y, ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                : CFG_W'($urandom_range(0, h * 256)));
            set_reg(REG_CELL_SIZE, ($urandom_range(2) == 0) ? 16'd256
                                   : CFG_W'($urandom_range(1, 65535)));
            items = n_sent + 19;
            while (n_sent < items)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    prep_and_expand($urandom_range(0, w * h - 1), 1'b1, 0);
                end
                else if (pick < 85 && w * h < CELLS)
                begin
                    push_expand($urandom_range(w * h, CELLS - 1));
                end
                else
                begin
                    push_write($urandom_range(0, CELLS - 1), OCC_W'($urandom));
                end
            end
            settle();
        end

        if (neighbor_queue.size() != 0)
        begin
            $error("%0d expected neighbors never arrived", neighbor_queue.size());
            fail_cnt++;
        end
        $display("covered %0d expansions, %0d occupancy writes, %0d register writes",
                 n_expands, n_writes, n_cfg);
        $display("checked %0d neighbor results over clamped, degenerate and random grids",
                 n_results);
        if (fail_cnt == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/gnce_pkg.sv
hw/rtl/gnce_ram.sv
hw/rtl/gnce_front.sv
hw/rtl/gnce_queue.sv
hw/rtl/gnce_back.sv
hw/rtl/grid_neighbor_cost_expander.sv
hw/rtl/gnce_checker.sv
tb/sv/tb_grid_neighbor_cost_expander.sv
